[hdl/wspm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspm_pkg
// Shared types and constants for the wildcard star pattern matcher.
// ----------------------------------------------------------------------------
package wspm_pkg;

	// Token store capacity and the width of a count that can hold it
	localparam int MAX_TOKENS = 16;
	localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

	// Input beat operations
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	// One pattern token: literal byte, any-byte flag, repeat flag
	typedef struct packed {
		logic       rep;
		logic       any;
		logic [7:0] lit;
	} token_t;

	// Broadcast control shared by every cell of the chain
	typedef struct packed {
		logic       accept;
		logic       consume;
		logic [7:0] text_byte;
		token_t     tok;
	} cell_ctrl_t;

	// One result beat
	typedef struct packed {
		logic matched;
		logic overflow;
	} result_t;

endpackage

[hdl/wspm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspm_cell
// One pattern cell: holds token k and the reach bit of the position after it.
// Computes the next closed reach bit of that position from its left neighbor.
// ----------------------------------------------------------------------------
module wspm_cell
	import wspm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       we,
	input  logic       live,
	input  logic       r_in,
	input  logic       c_in,
	input  logic       stay_in,
	output logic       r_out,
	output logic       c_out,
	output logic       stay_out
);

	token_t tok_q;
	token_t tok_nxt;
	logic   reach_q;
	logic   hit;
	logic   live_hit;
	logic   adv;

	// Load the token on append
	always_ff @(posedge clk) begin
		if (we) begin
			tok_q <= ctrl.tok;
		end
	end

	// Closure must see the token as it stands after this beat
	assign tok_nxt = we ? ctrl.tok : tok_q;

	// Match the text byte at this cell's position
	assign hit      = tok_q.any | (tok_q.lit == ctrl.text_byte);
	assign live_hit = ctrl.consume & r_in & live & hit;
	assign stay_out = live_hit & tok_q.rep;
	assign adv      = live_hit & ~tok_q.rep;

	// Advance, stay from the next token, or skip over a starred token
	assign c_out = adv | stay_in | (c_in & tok_nxt.rep & live);

	// Hold the reach bit of the following position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= 1'b0;
		end else if (ctrl.accept) begin
			reach_q <= c_out;
		end
	end

	assign r_out = reach_q;

endmodule

[hdl/wspm_out_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspm_out_skid
// Two-entry result buffer: an output register backed by a skid register,
// so the input side keeps flowing while a result beat waits.
// ----------------------------------------------------------------------------
module wspm_out_skid
	import wspm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t out_data,
	output logic    full
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop = main_vld_q & ~out_stall;

	// Advance the skid entry or the new beat into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || pop) begin
			main_vld_q <= skid_vld_q | push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!main_vld_q || pop) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_vld_q;
	assign out_data  = main_q;
	assign full      = skid_vld_q;

endmodule

[hdl/wildcard_star_pattern_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_star_pattern_matcher
// Whole-string match of streamed text against a loaded '.'/'*' token pattern.
// ----------------------------------------------------------------------------
// The block takes one beat per clock: clear, append token, text byte or end
// of text. The pattern sits in a row of MAX_TOKENS cells, each holding one
// token and one reachable-position bit; every beat updates the whole
// position set in that same cycle, so back-to-back beats never stall unless
// two result beats are already waiting at the output. An end-of-text beat
// returns its result through a two-entry output buffer, then
// the text restarts with the same pattern. Clear or append also restart the
// text. Appending past MAX_TOKENS drops the token and sets a sticky overflow
// flag that forces matched low until the next clear. The clock period is set
// by the ripple of the skip-over-star chain through all MAX_TOKENS cells.
// ----------------------------------------------------------------------------
module wildcard_star_pattern_matcher
	import wspm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] token_byte,
	input  logic       token_any,
	input  logic       token_repeat,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);

	op_t              op_c;
	logic             accept;
	logic             is_append;
	logic             is_full;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             ovf_q;
	logic             ovf_nxt;
	logic             pos0_q;
	cell_ctrl_t       ctrl;
	logic [MAX_TOKENS:0]   r;
	logic [MAX_TOKENS:0]   c;
	logic [MAX_TOKENS:0]   stay;
	logic [MAX_TOKENS-1:0] live;
	logic [MAX_TOKENS-1:0] we;
	result_t          res;
	result_t          out_data;
	logic             push;
	logic             buf_full;

	assign op_c      = op_t'(op);
	assign accept    = in_valid & ~in_stall;
	assign is_append = (op_c == OP_APPEND);
	assign is_full   = (count_q == CNT_W'(MAX_TOKENS));

	// Next pattern length and overflow flag
	always_comb begin
		count_nxt = count_q;
		ovf_nxt   = ovf_q;
		case (op_c)
			OP_CLEAR: begin
				count_nxt = '0;
				ovf_nxt   = 1'b0;
			end
			OP_APPEND: begin
				if (is_full) begin
					ovf_nxt = 1'b1;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			count_q <= count_nxt;
			ovf_q   <= ovf_nxt;
		end
	end

	// Broadcast the beat to the cells
	assign ctrl.accept    = accept;
	assign ctrl.consume   = (op_c == OP_TEXT);
	assign ctrl.text_byte = text_byte;
	assign ctrl.tok       = '{rep: token_repeat, any: token_any, lit: token_byte};

	// Position zero: seeded on restart, kept by a starred first token
	assign c[0] = ~ctrl.consume | stay[0];
	assign r[0] = pos0_q;
	assign stay[MAX_TOKENS] = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos0_q <= 1'b1;
		end else if (accept) begin
			pos0_q <= c[0];
		end
	end

	// Row of pattern cells
	for (genvar k = 0; k < MAX_TOKENS; k++) begin : g_cell
		assign live[k] = (CNT_W'(k) < count_nxt);
		assign we[k]   = accept & is_append & (count_q == CNT_W'(k));

		wspm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.we       (we[k]),
			.live     (live[k]),
			.r_in     (r[k]),
			.c_in     (c[k]),
			.stay_in  (stay[k+1]),
			.r_out    (r[k+1]),
			.c_out    (c[k+1]),
			.stay_out (stay[k])
		);
	end

	// Result on end of text
	assign res.matched  = r[count_q] & ~ovf_q;
	assign res.overflow = ovf_q;
	assign push         = accept & (op_c == OP_END);

	wspm_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (buf_full)
	);

	assign in_stall         = buf_full;
	assign matched          = out_data.matched;
	assign pattern_overflow = out_data.overflow;

	// Overflow only once the store is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> is_full)
		else $error("overflow flag set with room in the token store");

	// Clear restarts with an empty pattern at position zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_c == OP_CLEAR) |=> (count_q == '0 && pos0_q && !ovf_q))
		else $error("clear did not reset the pattern state");

	// A skid entry never exists without an output beat ahead of it
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_valid)
		else $error("skid entry held while output register empty");

	// An overflowed pattern never reports a match
	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && pattern_overflow))
		else $error("match reported with pattern overflow");

	// Positions past the pattern end stay unreachable
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		is_full || !r[MAX_TOKENS])
		else $error("final position reached past pattern length");

endmodule

[dv/tb_wildcard_star_pattern_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_star_pattern_matcher
// Self-checking bench for the '.'/'*' token pattern matcher.
// ----------------------------------------------------------------------------
// A scoreboard tracks the token store, the reachable position set and the
// sticky overflow flag, and queues one expected result per end-of-text beat.
// Stimulus opens with a short directed run (empty pattern and text, literal
// dot and star, any-byte and repeated tokens, byte extremes), then random
// pattern/text sequences built to match often, with broken texts, long
// patterns that overflow the store, and raw noise beats. Sender gaps and
// receiver stalls vary per phase; one long receiver hold-off fills the
// output buffer so the block stalls its input.
// ----------------------------------------------------------------------------
module tb_wildcard_star_pattern_matcher;
	import wspm_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int PHASE_BEATS     = 320;

	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_B    = 8'h62;

	// Expected behavior: token store, position set and pending match results
	class match_scoreboard;
		token_t              tokens[MAX_TOKENS];
		int                  n_tokens;
		logic [MAX_TOKENS:0] live;
		bit                  overflow;
		result_t             pending[$];
		int                  errors;

		function new();
			n_tokens = 0;
			overflow = 1'b0;
			errors   = 0;
			restart();
		endfunction

		// Let every reachable repeated token be skipped
		function logic [MAX_TOKENS:0] skip_stars(logic [MAX_TOKENS:0] s);
			for (int k = 0; k < n_tokens; k++) begin
				if (s[k] && tokens[k].rep)
					s[k + 1] = 1'b1;
			end
			return s;
		endfunction

		function void restart();
			live = skip_stars({{MAX_TOKENS{1'b0}}, 1'b1});
		endfunction

		function void note_beat(op_t o, logic [7:0] lit, logic tany, logic trep,
				logic [7:0] txt);
			logic [MAX_TOKENS:0] nxt;
			result_t             r;
			case (o)
			OP_CLEAR: begin
				n_tokens = 0;
				overflow = 1'b0;
				restart();
			end
			OP_APPEND: begin
				if (n_tokens < MAX_TOKENS) begin
					tokens[n_tokens].lit = lit;
					tokens[n_tokens].any = tany;
					tokens[n_tokens].rep = trep;
					n_tokens++;
				end else begin
					overflow = 1'b1;
				end
				restart();
			end
			OP_TEXT: begin
				nxt = '0;
				for (int k = 0; k < n_tokens; k++) begin
					if (live[k] && (tokens[k].any || tokens[k].lit == txt)) begin
						if (tokens[k].rep)
							nxt[k] = 1'b1;
						else
							nxt[k + 1] = 1'b1;
					end
				end
				live = skip_stars(nxt);
			end
			default: begin
				r.matched  = live[n_tokens] && !overflow;
				r.overflow = overflow;
				pending.push_back(r);
				restart();
			end
			endcase
		endfunction

		function void report(string field, logic exp_v, logic act_v);
			errors++;
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, exp_v,
				act_v);
		endfunction

		function void check_result(logic m, logic ov);
			result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual matched=%0b overflow=%0b",
					$time, m, ov);
				return;
			end
			e = pending.pop_front();
			if (m !== e.matched)
				report("matched", e.matched, m);
			if (ov !== e.overflow)
				report("pattern_overflow", e.overflow, ov);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] op;
	logic [7:0] token_byte;
	logic       token_any;
	logic       token_repeat;
	logic [7:0] text_byte;
	logic       out_valid;
	logic       out_stall;
	logic       matched;
	logic       pattern_overflow;

	match_scoreboard sb = new();

	int src_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int hold_req      = 0;
	int beats_sent    = 0;
	int idle_cycles   = 0;

	// Stimulus-side copy of the pattern being built, used to shape texts
	token_t     pat[32];
	logic [7:0] text_q[$];

	wildcard_star_pattern_matcher dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.token_byte       (token_byte),
		.token_any        (token_any),
		.token_repeat     (token_repeat),
		.text_byte        (text_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Drive receiver stall at the falling edge; honor long hold-off requests
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(matched, pattern_overflow);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(5))
		0: return CH_A;
		1: return CH_B;
		2: return CH_DOT;
		3: return CH_STAR;
		4: return $urandom_range(1) ? 8'hFF : 8'h00;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Offer one beat at the falling edge and hold it until accepted
	task automatic send_beat(op_t o, logic [7:0] lit, logic tany, logic trep,
			logic [7:0] txt);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		op           = o;
		token_byte   = (o == OP_APPEND) ? lit : 8'($urandom_range(255));
		token_any    = (o == OP_APPEND) ? tany : 1'($urandom_range(1));
		token_repeat = (o == OP_APPEND) ? trep : 1'($urandom_range(1));
		text_byte    = (o == OP_TEXT) ? txt : 8'($urandom_range(255));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_beat(o, token_byte, token_any, token_repeat, text_byte);
		beats_sent++;
		@(negedge clk);
	endtask

	// Pause the sender until every pending result has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Hold off the receiver while end-of-text beats pile up
	task automatic hold_and_fill();
		hold_req++;
		repeat (40)
			send_beat($urandom_range(1) ? OP_END : OP_TEXT, 8'h00, 1'b0, 1'b0, pick_byte());
		wait_drained();
	endtask

	// Random pattern/text sequences, broken texts and noise beats
	task automatic run_random(int stop_at);
		int len;
		int copies;
		int pos;
		while (beats_sent < stop_at) begin
			if ($urandom_range(99) < 8) begin
				send_beat(op_t'($urandom_range(3)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)),
					8'($urandom_range(255)));
				continue;
			end
			if ($urandom_range(9) != 0)
				send_beat(OP_CLEAR, 8'h00, 1'b0, 1'b0, 8'h00);
			// mostly short patterns, now and then a long one that may overflow the store
			len = ($urandom_range(9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				pat[i].lit = pick_byte();
				pat[i].any = ($urandom_range(3) == 0);
				pat[i].rep = 1'($urandom_range(1));
				send_beat(OP_APPEND, pat[i].lit, pat[i].any, pat[i].rep, 8'h00);
			end
			repeat ($urandom_range(1, 4)) begin
				// build a text that walks the pattern
				text_q.delete();
				for (int i = 0; i < len && i < MAX_TOKENS; i++) begin
					copies = pat[i].rep ? $urandom_range(3) : 1;
					repeat (copies)
						text_q.push_back(pat[i].any ? pick_byte() : pat[i].lit);
				end
				// break about a quarter of them
				if ($urandom_range(3) == 0) begin
					pos = $urandom_range(text_q.size());
					case ($urandom_range(2))
					0: text_q.insert(pos, pick_byte());
					1: if (pos < text_q.size()) text_q.delete(pos);
					default: if (pos < text_q.size()) text_q[pos] = pick_byte();
					endcase
				end
				foreach (text_q[i])
					send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, text_q[i]);
				if ($urandom_range(9) != 0)
					send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
			end
		end
	endtask

	initial begin
		in_valid     = 1'b0;
		op           = OP_CLEAR;
		token_byte   = 8'h00;
		token_any    = 1'b0;
		token_repeat = 1'b0;
		text_byte    = 8'h00;
		arst_n       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// empty pattern against empty and one-byte text
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		// literal dot matches only a dot
		send_beat(OP_APPEND, CH_DOT, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, CH_DOT);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, CH_A);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		// literal star matches only a star
		send_beat(OP_CLEAR, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_APPEND, CH_STAR, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, CH_STAR);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		// repeated literal and repeated any-byte, empty text included
		send_beat(OP_CLEAR, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_APPEND, 8'hFF, 1'b0, 1'b1, 8'h00);
		send_beat(OP_APPEND, 8'h00, 1'b1, 1'b1, 8'h00);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, 8'hFF);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, 8'h5A);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		// single token after stars: empty text no longer matches
		send_beat(OP_APPEND, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_TEXT, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_END, 8'h00, 1'b0, 1'b0, 8'h00);
		wait_drained();

		// random phases under different idling patterns
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				src_idle_pct  = 0;
				rcv_stall_pct = 0;
			end
			1: begin
				src_idle_pct  = 63;
				rcv_stall_pct = 0;
			end
			2: begin
				src_idle_pct  = 0;
				rcv_stall_pct = 63;
			end
			default: begin
				src_idle_pct  = 7;
				rcv_stall_pct = 7;
			end
			endcase
			if (phase == 0)
				hold_and_fill();
			run_random(beats_sent + PHASE_BEATS);
			wait_drained();
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
